// File: rtl/rcpc_pkg.sv
// Shared types and constants for the random cycle pointer chase unit.
// Used by rcpc_div and random_cycle_pointer_chase_unit; depends on nothing.
package rcpc_pkg;

    // Configuration register indexes.
    localparam logic CFG_ENTRY_COUNT  = 1'b0;
    localparam logic CFG_SHUFFLE_SEED = 1'b1;

    // Command codes.
    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_CHASE = 1'b1;

    localparam logic [16:0] ENTRY_RESET = 17'h10000;
    localparam logic [31:0] SEED_RESET  = 32'h12345678;
    localparam logic [31:0] RNG_RESET   = 32'h12345678;

    // Divider dividend width and iteration counts.
    localparam int DIV_W = 48;
    localparam logic [5:0] DIV_ITERS_STEPS = 6'(DIV_W);
    localparam logic [5:0] DIV_ITERS_RNG   = 6'd32;

    typedef struct packed {
        logic       start;
        logic [5:0] iters;
    } div_ctl_t;

    typedef enum logic [14:0] {
        ST_IDLE     = 15'b000000000000001,
        ST_INIT     = 15'b000000000000010,
        ST_SH_RNG   = 15'b000000000000100,
        ST_SH_DIV   = 15'b000000000001000,
        ST_SH_WRI   = 15'b000000000010000,
        ST_SH_WRJ   = 15'b000000000100000,
        ST_LINK     = 15'b000000001000000,
        ST_LINK_END = 15'b000000010000000,
        ST_CH_DIV   = 15'b000000100000000,
        ST_CH_LS    = 15'b000001000000000,
        ST_CH_LM    = 15'b000010000000000,
        ST_WALK_RD  = 15'b000100000000000,
        ST_WALK     = 15'b001000000000000,
        ST_FINISH   = 15'b010000000000000,
        ST_SPARE    = 15'b100000000000000
    } state_t;

    // One xorshift32 step with shifts 13, 17 and 5.
    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

// File: rtl/rcpc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rcpc_pkg for the dividend width and the control struct.
module rcpc_div #(
    parameter int NW = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rcpc_pkg::div_ctl_t          ctl,
    input  logic [rcpc_pkg::DIV_W-1:0]  dividend,
    input  logic [NW-1:0]               divisor,
    output logic                        done,
    output logic [rcpc_pkg::DIV_W-1:0]  quotient,
    output logic [NW-1:0]               remainder
);
    import rcpc_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [NW-1:0]    dsr_reg;
    logic [NW-1:0]    rem_reg;
    logic [NW:0]      trial;
    logic [NW:0]      diff;
    logic             ge;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctl.iters;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[NW-1:0] : trial[NW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/random_cycle_pointer_chase_unit.sv
// Random cycle pointer chase unit: builds a shuffled single-cycle successor table and walks it.
// Depends on rcpc_pkg and rcpc_div. Build does n init writes, then per swap a modulo of
// a random word in states SH_RNG and SH_DIV and the writes SH_WRI and SH_WRJ, then a link pass.
// Chase divides step_count by the cycle length, runs two shift-add multiplies, one bit per
// cycle in each multiply, and one dependent successor read per step. One command at a time.
// Reset restores the default registers and clears the built flag; tables hold no reset value.
module random_cycle_pointer_chase_unit #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [47:0] step_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] index_sum,
    output logic [15:0] final_index,
    output logic        status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import rcpc_pkg::*;

    // Index width of the tables, and a count width that can hold the depth itself.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;
    localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

    // Two tables, each with one write port and one read port with registered read data.
    logic [AW-1:0] sh_mem [TABLE_DEPTH];
    logic [AW-1:0] sc_mem [TABLE_DEPTH];
    logic          sh_we, sh_re, sc_we, sc_re;
    logic [AW-1:0] sh_waddr, sh_wdata, sh_raddr, sh_q;
    logic [AW-1:0] sc_waddr, sc_wdata, sc_raddr, sc_q;

    // Control registers.
    state_t        state_reg, state_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] len_reg, len_next;
    logic          built_reg, built_next;
    logic [31:0]   rng_reg, rng_next;
    logic [16:0]   entry_reg;
    logic [31:0]   seed_reg;
    logic          dv_reg, dv_next;
    logic          pf_reg, pf_next;
    logic          out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [NW-1:0] n_reg, n_next;
    logic [AW-1:0] ti_reg, ti_next;
    logic [AW-1:0] first_reg, first_next;
    logic [AW-1:0] prev_reg, prev_next;
    logic [NW-1:0] rest_reg, rest_next;
    logic [63:0]   mul_a_reg, mul_a_next;
    logic [47:0]   mul_b_reg, mul_b_next;
    logic [63:0]   acc_reg, acc_next;
    logic [63:0]   sum_reg, sum_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          stat_reg, stat_next;
    logic [63:0]   sum_out_reg, sum_out_next;
    logic [15:0]   fidx_out_reg, fidx_out_next;
    logic          stat_out_reg, stat_out_next;

    // Shared divider: modulo of each random word during a shuffle, and laps/rest of a chase.
    div_ctl_t         div_ctl;
    logic [DIV_W-1:0] div_dividend;
    logic [NW-1:0]    div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [NW-1:0]    div_rem;

    logic [NW-1:0] n_clamp;
    logic [31:0]   rng_step;
    logic          can_finish;

    rcpc_div #(
        .NW (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // An entry count of zero builds one entry; a count beyond the table builds the whole table.
    always_comb
    begin
        if (entry_reg == 17'd0)
            n_clamp = NW'(1);
        else if (32'(entry_reg) > 32'(TABLE_DEPTH))
            n_clamp = DEPTH_N;
        else
            n_clamp = NW'(entry_reg);
    end

    assign rng_step   = xorshift32(rng_reg);
    assign can_finish = !out_valid_reg || !out_stall;

    // The divisor is the lap length in a chase and i+1 in a shuffle.
    assign div_divisor = (state_reg == ST_IDLE) ? len_reg : (i_reg + NW'(1));

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        len_next       = len_reg;
        built_next     = built_reg;
        rng_next       = rng_reg;
        dv_next        = dv_reg;
        pf_next        = pf_reg;
        out_valid_next = out_valid_reg;
        n_next         = n_reg;
        ti_next        = ti_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        rest_next      = rest_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        stat_next      = stat_reg;
        sum_out_next   = sum_out_reg;
        fidx_out_next  = fidx_out_reg;
        stat_out_next  = stat_out_reg;

        div_ctl        = '{start: 1'b0, iters: 6'd0};
        div_dividend   = '0;
        sh_we    = 1'b0;
        sh_waddr = '0;
        sh_wdata = '0;
        sh_re    = 1'b0;
        sh_raddr = '0;
        sc_we    = 1'b0;
        sc_waddr = '0;
        sc_wdata = '0;
        sc_re    = 1'b0;
        sc_raddr = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sum_next  = '0;
                    idx_next  = '0;
                    stat_next = 1'b0;
                    if (cmd == CMD_BUILD)
                    begin
                        n_next     = n_clamp;
                        i_next     = '0;
                        rng_next   = seed_reg;
                        state_next = ST_INIT;
                    end
                    else if (!built_reg)
                    begin
                        stat_next  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_ctl      = '{start: 1'b1, iters: DIV_ITERS_STEPS};
                        div_dividend = step_count;
                        state_next   = ST_CH_DIV;
                    end
                end
            end

            // Identity permutation, one entry per cycle.
            ST_INIT:
            begin
                sh_we    = 1'b1;
                sh_waddr = i_reg[AW-1:0];
                sh_wdata = i_reg[AW-1:0];
                if (i_reg == n_reg - NW'(1))
                begin
                    if (n_reg == NW'(1))
                    begin
                        i_next     = '0;
                        dv_next    = 1'b0;
                        pf_next    = 1'b0;
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        state_next = ST_SH_RNG;
                    end
                end
                else
                begin
                    i_next = i_reg + NW'(1);
                end
            end

            // Draw a word, start its modulo, and fetch entry i meanwhile.
            ST_SH_RNG:
            begin
                rng_next     = rng_step;
                div_ctl      = '{start: 1'b1, iters: DIV_ITERS_RNG};
                div_dividend = {rng_step, (DIV_W - 32)'(0)};
                sh_re        = 1'b1;
                sh_raddr     = i_reg[AW-1:0];
                state_next   = ST_SH_DIV;
            end

            ST_SH_DIV:
            begin
                if (div_done)
                begin
                    ti_next    = sh_q;
                    sh_re      = 1'b1;
                    sh_raddr   = div_rem[AW-1:0];
                    state_next = ST_SH_WRI;
                end
            end

            ST_SH_WRI:
            begin
                sh_we      = 1'b1;
                sh_waddr   = i_reg[AW-1:0];
                sh_wdata   = sh_q;
                state_next = ST_SH_WRJ;
            end

            ST_SH_WRJ:
            begin
                sh_we    = 1'b1;
                sh_waddr = div_rem[AW-1:0];
                sh_wdata = ti_reg;
                if (i_reg == NW'(1))
                begin
                    i_next     = '0;
                    dv_next    = 1'b0;
                    pf_next    = 1'b0;
                    state_next = ST_LINK;
                end
                else
                begin
                    i_next     = i_reg - NW'(1);
                    state_next = ST_SH_RNG;
                end
            end

            // Stream the shuffled order out and link each entry to the one after it.
            ST_LINK:
            begin
                if (i_reg != n_reg)
                begin
                    sh_re    = 1'b1;
                    sh_raddr = i_reg[AW-1:0];
                    i_next   = i_reg + NW'(1);
                    dv_next  = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                end
                if (dv_reg)
                begin
                    prev_next = sh_q;
                    if (!pf_reg)
                    begin
                        first_next = sh_q;
                        pf_next    = 1'b1;
                    end
                    else
                    begin
                        sc_we    = 1'b1;
                        sc_waddr = prev_reg;
                        sc_wdata = sh_q;
                    end
                end
                else if (i_reg == n_reg)
                begin
                    state_next = ST_LINK_END;
                end
            end

            // Close the cycle: last entry links back to the first.
            ST_LINK_END:
            begin
                sc_we      = 1'b1;
                sc_waddr   = prev_reg;
                sc_wdata   = first_reg;
                len_next   = n_reg;
                built_next = 1'b1;
                state_next = ST_FINISH;
            end

            ST_CH_DIV:
            begin
                if (div_done)
                begin
                    rest_next  = div_rem;
                    mul_a_next = 64'(len_reg);
                    mul_b_next = 48'(len_reg - NW'(1));
                    acc_next   = '0;
                    state_next = ST_CH_LS;
                end
            end

            // Shift-add multiply len*(len-1), then halve for the lap sum.
            ST_CH_LS:
            begin
                if (mul_b_reg == 48'd0)
                begin
                    mul_a_next = acc_reg >> 1;
                    mul_b_next = div_quot;
                    acc_next   = '0;
                    state_next = ST_CH_LM;
                end
                else
                begin
                    if (mul_b_reg[0])
                        acc_next = acc_reg + mul_a_reg;
                    mul_a_next = mul_a_reg << 1;
                    mul_b_next = mul_b_reg >> 1;
                end
            end

            // Shift-add multiply laps by the lap sum, wrapping at 64 bits.
            ST_CH_LM:
            begin
                if (mul_b_reg == 48'd0)
                begin
                    sum_next = acc_reg;
                    idx_next = '0;
                    if (rest_reg == '0)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_WALK_RD;
                end
                else
                begin
                    if (mul_b_reg[0])
                        acc_next = acc_reg + mul_a_reg;
                    mul_a_next = mul_a_reg << 1;
                    mul_b_next = mul_b_reg >> 1;
                end
            end

            ST_WALK_RD:
            begin
                sc_re      = 1'b1;
                sc_raddr   = idx_reg;
                state_next = ST_WALK;
            end

            // Each read result is the next address, one dependent step per cycle.
            ST_WALK:
            begin
                idx_next  = sc_q;
                sum_next  = sum_reg + 64'(sc_q);
                rest_next = rest_reg - NW'(1);
                if (rest_reg == NW'(1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    sc_re    = 1'b1;
                    sc_raddr = sc_q;
                end
            end

            ST_FINISH:
            begin
                if (can_finish)
                begin
                    out_valid_next = 1'b1;
                    sum_out_next   = sum_reg;
                    fidx_out_next  = 16'(idx_reg);
                    stat_out_next  = stat_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            len_reg       <= '0;
            built_reg     <= 1'b0;
            rng_reg       <= RNG_RESET;
            dv_reg        <= 1'b0;
            pf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            len_reg       <= len_next;
            built_reg     <= built_next;
            rng_reg       <= rng_next;
            dv_reg        <= dv_next;
            pf_reg        <= pf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers; writes are always taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= ENTRY_RESET;
            seed_reg  <= SEED_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT:  entry_reg <= cfg_data[16:0];
                CFG_SHUFFLE_SEED: seed_reg  <= cfg_data;
                default:          entry_reg <= entry_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        ti_reg       <= ti_next;
        first_reg    <= first_next;
        prev_reg     <= prev_next;
        rest_reg     <= rest_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        acc_reg      <= acc_next;
        sum_reg      <= sum_next;
        idx_reg      <= idx_next;
        stat_reg     <= stat_next;
        sum_out_reg  <= sum_out_next;
        fidx_out_reg <= fidx_out_next;
        stat_out_reg <= stat_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (sh_we)
            sh_mem[sh_waddr] <= sh_wdata;
        if (sh_re)
            sh_q <= sh_mem[sh_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sc_we)
            sc_mem[sc_waddr] <= sc_wdata;
        if (sc_re)
            sc_q <= sc_mem[sc_raddr];
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign index_sum   = sum_out_reg;
    assign final_index = fidx_out_reg;
    assign status      = stat_out_reg;

endmodule

// File: bench/random_cycle_pointer_chase_unit_tb.sv
// Self-checking bench for the random cycle pointer chase unit.
// Depends on rcpc_pkg and the unit itself; a scoreboard class predicts each result word.
`timescale 1ns / 1ps

module random_cycle_pointer_chase_unit_tb;
    import rcpc_pkg::*;

    localparam int DEPTH = 65536;

    // One predicted result word.
    typedef struct {
        logic [63:0] index_sum;
        logic [15:0] final_index;
        logic        status;
    } chase_result_t;

    // The scoreboard keeps its own copy of the tables, the generator and the registers.
    // Every accepted command word is predicted at once; results are matched in order.
    class chase_scoreboard;
        logic [15:0]   succ_tbl [DEPTH];
        logic [15:0]   perm_tbl [DEPTH];
        logic [31:0]   rng;
        logic [16:0]   entries;
        logic [31:0]   seed;
        bit            built;
        int unsigned   cycle_len;
        chase_result_t pending[$];
        int            errors;

        function new();
            rng       = RNG_RESET;
            entries   = ENTRY_RESET;
            seed      = SEED_RESET;
            built     = 0;
            cycle_len = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == CFG_ENTRY_COUNT)
                entries = data[16:0];
            else
                seed = data;
        endfunction

        function logic [31:0] next_rng();
            logic [31:0] x;
            x = rng;
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            rng = x;
            return x;
        endfunction

        function void note_command(logic c, logic [47:0] steps);
            chase_result_t r;
            int unsigned n;
            int unsigned j;
            logic [15:0] t;
            logic [63:0] len;
            logic [63:0] rest;
            logic [63:0] sum;
            logic [15:0] idx;
            r.index_sum   = '0;
            r.final_index = '0;
            r.status      = 1'b0;
            if (c == CMD_BUILD) begin
                n = 32'(entries);
                if (n < 1) n = 1;
                if (n > DEPTH) n = DEPTH;
                rng = seed;
                for (int i = 0; i < n; i++) perm_tbl[i] = 16'(i);
                for (int unsigned i = n - 1; i > 0; i--) begin
                    j = next_rng() % (i + 1);
                    t = perm_tbl[i];
                    perm_tbl[i] = perm_tbl[j];
                    perm_tbl[j] = t;
                end
                for (int i = 0; i + 1 < n; i++) succ_tbl[perm_tbl[i]] = perm_tbl[i + 1];
                succ_tbl[perm_tbl[n - 1]] = perm_tbl[0];
                cycle_len = n;
                built = 1;
            end else if (!built) begin
                r.status = 1'b1;
            end else begin
                // Whole laps add a fixed sum; only the remainder is walked.
                len  = 64'(cycle_len);
                rest = {16'b0, steps} % len;
                sum  = ({16'b0, steps} / len) * ((len * (len - 1)) / 2);
                idx  = '0;
                for (longint unsigned k = 0; k < rest; k++) begin
                    idx = succ_tbl[idx];
                    sum = sum + 64'(idx);
                end
                r.index_sum   = sum;
                r.final_index = idx;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [63:0] s, logic [15:0] f, logic st);
            chase_result_t e;
            if (pending.size() == 0) begin
                $error("result word arrived with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (s !== e.index_sum) begin
                $error("index_sum expected %0h actual %0h", e.index_sum, s);
                errors++;
            end
            if (f !== e.final_index) begin
                $error("final_index expected %0h actual %0h", e.final_index, f);
                errors++;
            end
            if (st !== e.status) begin
                $error("status expected %0b actual %0b", e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = 1'b0;
    logic [47:0] step_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] index_sum;
    logic [15:0] final_index;
    logic        status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    // Idle and stall odds, in percent, for the current phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    chase_scoreboard sb = new();

    always #1 clk = ~clk;

    random_cycle_pointer_chase_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .step_count (step_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .index_sum  (index_sum),
        .final_index(final_index),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Result side. Outputs are sampled before this edge's updates land, so the
    // handshake seen here is the one that completes at this edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(index_sum, final_index, status);
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Sends one command word. The caller is at a rising edge; valid stays high
    // straight into the next word when no gap is drawn.
    task automatic send_command(logic c, logic [47:0] steps);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        step_count <= steps;
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        sb.note_command(c, steps);
    endtask

    // Waits until every predicted word has come back and drops valid.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Register write; only called once the unit is idle.
    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Step counts: short walks, near whole laps, the all-ones maximum, and wide random values.
    function automatic logic [47:0] pick_steps(int unsigned len);
        int unsigned k;
        k = $urandom_range(9);
        if (k < 4) return 48'($urandom_range(200));
        if (k < 6) return 48'(len * $urandom_range(20) + $urandom_range(2));
        if (k == 6) return '1;
        return 48'({$urandom(), $urandom()});
    endfunction

    int unsigned phase_send [4] = '{0, 83, 0, 20};
    int unsigned phase_recv [4] = '{0, 0, 83, 20};

    initial begin
        int unsigned n;
        logic [31:0] s;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. A chase with no table built reports an error.
        send_command(CMD_CHASE, 48'd5);
        drain();
        // An entry count of zero acts as one entry linking to itself; a zero seed
        // keeps the generator at zero.
        write_reg(CFG_ENTRY_COUNT, 32'd0);
        write_reg(CFG_SHUFFLE_SEED, 32'd0);
        send_command(CMD_BUILD, '1);
        send_command(CMD_CHASE, 48'd0);
        send_command(CMD_CHASE, 48'd1);
        send_command(CMD_CHASE, '1);
        drain();
        write_reg(CFG_ENTRY_COUNT, 32'd2);
        write_reg(CFG_SHUFFLE_SEED, 32'hFFFF_FFFF);
        send_command(CMD_BUILD, 48'd0);
        send_command(CMD_CHASE, 48'd3);
        drain();
        // A new entry count does not touch the cycle already built.
        write_reg(CFG_ENTRY_COUNT, 32'd5);
        write_reg(CFG_SHUFFLE_SEED, 32'd1);
        send_command(CMD_CHASE, 48'd7);
        send_command(CMD_BUILD, 48'd0);
        send_command(CMD_CHASE, 48'd11);
        send_command(CMD_CHASE, 48'hAAAA_AAAA_AAAA);
        drain();
        // An over-range entry count clamps to the full table; the one large build.
        write_reg(CFG_ENTRY_COUNT, 32'h1_FFFF);
        write_reg(CFG_SHUFFLE_SEED, SEED_RESET);
        send_command(CMD_BUILD, 48'd0);
        send_command(CMD_CHASE, '1);
        send_command(CMD_CHASE, 48'd70000);
        send_command(CMD_CHASE, 48'd65535);
        send_command(CMD_CHASE, 48'h5555_5555_5555);
        drain();

        // Random part: four idling phases of small tables, mostly chases.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (int b = 0; b < 3; b++) begin
                n = $urandom_range(9) == 0 ? $urandom_range(2) : $urandom_range(3, 48);
                s = $urandom_range(9) == 0 ? 32'hFFFF_FFFF : $urandom();
                write_reg(CFG_ENTRY_COUNT, n);
                write_reg(CFG_SHUFFLE_SEED, s);
                if (n == 0) n = 1;
                send_command(CMD_BUILD, 48'({$urandom(), $urandom()}));
                for (int k = 0; k < 8; k++) begin
                    if ($urandom_range(7) == 0)
                        send_command(CMD_BUILD, pick_steps(n));
                    else
                        send_command(CMD_CHASE, pick_steps(n));
                end
                drain();
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: reports a failure and ends the run if the regression hangs.
    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
